FILE: design/bld_pkg.sv
// Package for the lens distortion block: fixed-point types, constants, helpers.
// Used by every module of the block; no dependencies.
package bld_pkg;

  localparam int MaxIter  = 32;
  localparam int FracBits = 28;
  localparam int IterW    = 9;
  localparam int QDepth   = 2;

  typedef logic signed [31:0] q_t;

  typedef enum logic [2:0] {
    CfgK1  = 3'd0,
    CfgK2  = 3'd1,
    CfgK3  = 3'd2,
    CfgT1  = 3'd3,
    CfgT2  = 3'd4,
    CfgTol = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic remove;
    q_t   px;
    q_t   py;
  } job_t;

  typedef struct packed {
    q_t               x;
    q_t               y;
    logic             conv;
    logic [IterW-1:0] iters;
  } res_t;

  typedef enum logic [1:0] {
    StIdle,
    StCalc,
    StCheck,
    StDone
  } eng_st_t;

  function automatic q_t sat33(input logic signed [32:0] v);
    if (v > 33'sd2147483647) return 32'sh7fffffff;
    if (v < -33'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    return sat33(33'(a) + 33'(b));
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    return sat33(33'(a) - 33'(b));
  endfunction

  function automatic q_t qdbl(input q_t a);
    return sat33({a, 1'b0});
  endfunction

  function automatic q_t qround(input logic signed [63:0] p);
    logic signed [64:0] t;
    logic signed [64:0] s;
    t = 65'(p) + (65'sd1 <<< (FracBits - 1));
    s = t >>> FracBits;
    if (s > 65'sd2147483647) return 32'sh7fffffff;
    if (s < -65'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

endpackage

FILE: design/bld_front.sv
// Front end: accepts input transactions into a short job queue.
// Depends on bld_pkg.
module bld_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  bld_pkg::job_t job_in,
  output logic          job_valid,
  input  logic          job_take,
  output bld_pkg::job_t job_out
);

  bld_pkg::job_t q_r [bld_pkg::QDepth];
  logic          rd_r;
  logic          wr_r;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full      = (cnt_r == 2'(bld_pkg::QDepth));
  assign job_valid = (cnt_r != 2'd0);
  assign job_out   = q_r[rd_r];
  assign do_push   = push && !full;
  assign do_pop    = job_take && job_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_r <= ~wr_r;
      if (do_pop) rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wr_r] <= job_in;
  end

endmodule

FILE: design/bld_engine.sv
// Back end: evaluates the distortion polynomial on one shared multiplier,
// iterates the inverse, and holds the result. Depends on bld_pkg.
module bld_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_take,
  input  bld_pkg::job_t job,
  input  bld_pkg::q_t   k1,
  input  bld_pkg::q_t   k2,
  input  bld_pkg::q_t   k3,
  input  bld_pkg::q_t   t1,
  input  bld_pkg::q_t   t2,
  input  logic [15:0]   tol,
  output logic          res_valid,
  input  logic          res_take,
  output bld_pkg::res_t res
);

  localparam int NStep = 22;

  bld_pkg::eng_st_t st_r, st_nxt;
  logic [4:0]   step_r;
  bld_pkg::job_t job_r;
  bld_pkg::q_t  ux_r, uy_r;
  bld_pkg::q_t  xx_r, yy_r, r2_r, r4_r, r6_r, kd_r, xy2_r, tx_r, ty_r, tmp_r;
  bld_pkg::q_t  dx_r, dy_r;
  logic [bld_pkg::IterW-1:0] it_r;
  bld_pkg::res_t res_r;
  logic          rv_r;

  bld_pkg::q_t  ma, mb, m;
  logic signed [63:0] prod;
  logic signed [33:0] ex, ey;
  logic [34:0] l1;
  logic        last_step;

  assign prod = 64'(ma) * 64'(mb);
  assign m    = bld_pkg::qround(prod);
  assign last_step = (step_r == 5'(NStep - 1));

  always_comb begin
    ma = ux_r;
    mb = ux_r;
    case (step_r)
      5'd0:  begin ma = ux_r;  mb = ux_r;  end
      5'd1:  begin ma = uy_r;  mb = uy_r;  end
      5'd2:  begin ma = r2_r;  mb = r2_r;  end
      5'd3:  begin ma = r4_r;  mb = r2_r;  end
      5'd4:  begin ma = k1;    mb = r2_r;  end
      5'd5:  begin ma = k2;    mb = r4_r;  end
      5'd6:  begin ma = k3;    mb = r6_r;  end
      5'd7:  begin ma = ux_r;  mb = uy_r;  end
      5'd8:  begin ma = t2;    mb = bld_pkg::qadd(r2_r, bld_pkg::qdbl(xx_r)); end
      5'd9:  begin ma = t1;    mb = xy2_r; end
      5'd10: begin ma = t1;    mb = bld_pkg::qadd(r2_r, bld_pkg::qdbl(yy_r)); end
      5'd11: begin ma = t2;    mb = xy2_r; end
      5'd12: begin ma = ux_r;  mb = kd_r;  end
      5'd13: begin ma = uy_r;  mb = kd_r;  end
      default: begin ma = ux_r; mb = ux_r; end
    endcase
  end

  always_comb begin
    ex = 34'(ux_r) + 34'(dx_r) - 34'(job_r.px);
    ey = 34'(uy_r) + 34'(dy_r) - 34'(job_r.py);
    l1 = 35'(ex[33] ? -ex : ex) + 35'(ey[33] ? -ey : ey);
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bld_pkg::StIdle:  if (job_valid && !rv_r) st_nxt = bld_pkg::StCalc;
      bld_pkg::StCalc:  if (last_step) st_nxt = bld_pkg::StCheck;
      bld_pkg::StCheck: begin
        if (!job_r.remove || l1 <= 35'(tol) ||
            it_r >= bld_pkg::IterW'(bld_pkg::MaxIter)) begin
          st_nxt = bld_pkg::StDone;
        end else begin
          st_nxt = bld_pkg::StCalc;
        end
      end
      bld_pkg::StDone:  st_nxt = bld_pkg::StIdle;
      default:          st_nxt = bld_pkg::StIdle;
    endcase
  end

  always_comb begin
    job_take = (st_r == bld_pkg::StIdle) && job_valid && !rv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= bld_pkg::StIdle;
      step_r <= 5'd0;
      rv_r   <= 1'b0;
      it_r   <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == bld_pkg::StCalc) step_r <= last_step ? 5'd0 : step_r + 5'd1;
      if (job_take) it_r <= '0;
      if (st_r == bld_pkg::StCheck && st_nxt == bld_pkg::StCalc)
        it_r <= it_r + bld_pkg::IterW'(1);
      if (st_r == bld_pkg::StDone) rv_r <= 1'b1;
      else if (res_take && rv_r) rv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      job_r <= job;
      ux_r  <= job.px;
      uy_r  <= job.py;
    end
    if (st_r == bld_pkg::StCalc) begin
      case (step_r)
        5'd0:  xx_r  <= m;
        5'd1:  begin yy_r <= m; r2_r <= bld_pkg::qadd(xx_r, m); end
        5'd2:  r4_r  <= m;
        5'd3:  r6_r  <= m;
        5'd4:  tmp_r <= m;
        5'd5:  tmp_r <= bld_pkg::qadd(tmp_r, m);
        5'd6:  kd_r  <= bld_pkg::qadd(tmp_r, m);
        5'd7:  xy2_r <= bld_pkg::qdbl(m);
        5'd8:  tmp_r <= m;
        5'd9:  tx_r  <= bld_pkg::qadd(tmp_r, m);
        5'd10: tmp_r <= m;
        5'd11: ty_r  <= bld_pkg::qadd(tmp_r, m);
        5'd12: dx_r  <= bld_pkg::qadd(m, tx_r);
        5'd13: dy_r  <= bld_pkg::qadd(m, ty_r);
        default: ;
      endcase
    end
    if (st_r == bld_pkg::StCheck) begin
      if (!job_r.remove) begin
        res_r.x     <= bld_pkg::qadd(job_r.px, dx_r);
        res_r.y     <= bld_pkg::qadd(job_r.py, dy_r);
        res_r.conv  <= 1'b1;
        res_r.iters <= '0;
      end else begin
        res_r.x     <= ux_r;
        res_r.y     <= uy_r;
        res_r.conv  <= (l1 <= 35'(tol));
        res_r.iters <= it_r;
        if (st_nxt == bld_pkg::StCalc) begin
          ux_r <= bld_pkg::qsub(job_r.px, dx_r);
          uy_r <= bld_pkg::qsub(job_r.py, dy_r);
        end
      end
    end
  end

  assign res_valid = rv_r;
  assign res       = res_r;

endmodule

FILE: design/brown_lens_distortion_top.sv
// Top level of the Brown-Conrady lens distortion block.
// Depends on bld_pkg, bld_front, bld_engine.
//
//  channel | handshake      | payload
//  in_     | push / full    | in_req_type, in_point_x, in_point_y
//  out_    | empty / pop    | out_out_x, out_out_y, out_converged, out_iteration_count
//  cfg_    | valid / ready  | cfg_index, cfg_data
//
// Each distortion evaluation runs step by step on the single 32x32 multiplier.
// Add mode evaluates once per item; remove mode evaluates once more per iteration,
// up to 32 iterations. Reset is synchronous. The engine takes one item at a time.
// Two inputs queue ahead of the engine; one result waits in the output register.
module brown_lens_distortion_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_req_type,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  output logic        empty,
  input  logic        pop,
  output logic signed [31:0] out_out_x,
  output logic signed [31:0] out_out_y,
  output logic        out_converged,
  output logic [8:0]  out_iteration_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  bld_pkg::q_t   k1_r, k2_r, k3_r, t1_r, t2_r;
  logic [15:0]   tol_r;
  bld_pkg::job_t job_in, job_q;
  logic          job_valid, job_take, res_valid;
  bld_pkg::res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r  <= '0;
      k2_r  <= '0;
      k3_r  <= '0;
      t1_r  <= '0;
      t2_r  <= '0;
      tol_r <= 16'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bld_pkg::CfgK1:  k1_r  <= cfg_data;
        bld_pkg::CfgK2:  k2_r  <= cfg_data;
        bld_pkg::CfgK3:  k3_r  <= cfg_data;
        bld_pkg::CfgT1:  t1_r  <= cfg_data;
        bld_pkg::CfgT2:  t2_r  <= cfg_data;
        bld_pkg::CfgTol: tol_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign job_in = '{remove: in_req_type, px: in_point_x, py: in_point_y};

  bld_front u_front (
    .clk, .rst_n, .push, .full, .job_in,
    .job_valid, .job_take, .job_out(job_q)
  );

  bld_engine u_engine (
    .clk, .rst_n, .job_valid, .job_take, .job(job_q),
    .k1(k1_r), .k2(k2_r), .k3(k3_r), .t1(t1_r), .t2(t2_r), .tol(tol_r),
    .res_valid, .res_take(pop), .res
  );

  assign empty               = !res_valid;
  assign out_out_x           = res.x;
  assign out_out_y           = res.y;
  assign out_converged       = res.conv;
  assign out_iteration_count = res.iters;

endmodule

FILE: design/bld_checker.sv
// Port-level checker for the lens distortion block, bound to the top level.
// Depends on brown_lens_distortion_top ports only.
module bld_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic        out_converged,
  input logic [8:0]  out_iteration_count
);

  a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_iteration_count <= 9'd32) else $error("iteration count too big");

  a_noconv_max: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_converged) |-> out_iteration_count == 9'd32)
    else $error("unconverged before limit");

  a_pop_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty) |=> empty) else $error("result repeated");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_iteration_count)))
    else $error("result lost");

endmodule

bind brown_lens_distortion_top bld_checker u_bld_checker (
  .clk, .rst_n, .empty, .pop, .out_converged, .out_iteration_count
);

FILE: sim/tb_brown_lens_distortion_top.sv
// Self-checking testbench for brown_lens_distortion_top: directed table, then random phases.
// Predicts add/remove results in fixed point; depends on bld_pkg and the block's RTL.
module tb_brown_lens_distortion_top;

  localparam longint CycleLimit = 8000000;
  localparam logic [2:0] CfgSpare6 = 3'd6;
  localparam logic [2:0] CfgSpare7 = 3'd7;
  localparam bld_pkg::q_t QMax = 32'sh7fffffff;
  localparam bld_pkg::q_t QMin = 32'sh80000000;
  localparam bld_pkg::q_t QOne = 32'sh10000000;

  typedef struct {
    logic             remove;
    bld_pkg::q_t      x;
    bld_pkg::q_t      y;
    bit               typed;
    bld_pkg::res_t    ans;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             push = 1'b0;
  logic             full;
  logic             in_req_type = 1'b0;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic             empty;
  logic             pop = 1'b0;
  logic signed [31:0] out_out_x;
  logic signed [31:0] out_out_y;
  logic             out_converged;
  logic [8:0]       out_iteration_count;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [2:0]       cfg_index = '0;
  logic [31:0]      cfg_data = '0;

  bld_pkg::q_t   k1_m, k2_m, k3_m, t1_m, t2_m;
  logic [15:0]   tol_m;
  bld_pkg::res_t pending_q[$];
  int            errors = 0;
  longint        cycles = 0;
  int            pop_hold = 0;
  row_t          dir_tab[14];

  brown_lens_distortion_top u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bld_pkg::q_t sat_q(input longint v);
    if (v > 64'sd2147483647) return QMax;
    if (v < -64'sd2147483648) return QMin;
    return bld_pkg::q_t'(v);
  endfunction

  function automatic bld_pkg::q_t mul_q(input bld_pkg::q_t a, input bld_pkg::q_t b);
    longint p;
    p = longint'(a) * longint'(b) + (64'sd1 <<< (bld_pkg::FracBits - 1));
    return sat_q(p >>> bld_pkg::FracBits);
  endfunction

  function automatic bld_pkg::q_t add_q(input bld_pkg::q_t a, input bld_pkg::q_t b);
    return sat_q(longint'(a) + longint'(b));
  endfunction

  function automatic void lens_offset(input bld_pkg::q_t x, input bld_pkg::q_t y,
                                      output bld_pkg::q_t dx, output bld_pkg::q_t dy);
    bld_pkg::q_t xx, yy, r2, r4, r6, kd, xy2, tx, ty;
    xx  = mul_q(x, x);
    yy  = mul_q(y, y);
    r2  = add_q(xx, yy);
    r4  = mul_q(r2, r2);
    r6  = mul_q(r4, r2);
    kd  = add_q(add_q(mul_q(k1_m, r2), mul_q(k2_m, r4)), mul_q(k3_m, r6));
    xy2 = sat_q(2 * longint'(mul_q(x, y)));
    tx  = add_q(mul_q(t2_m, add_q(r2, sat_q(2 * longint'(xx)))), mul_q(t1_m, xy2));
    ty  = add_q(mul_q(t1_m, add_q(r2, sat_q(2 * longint'(yy)))), mul_q(t2_m, xy2));
    dx  = add_q(mul_q(x, kd), tx);
    dy  = add_q(mul_q(y, kd), ty);
  endfunction

  function automatic bld_pkg::res_t lens_result(input logic remove, input bld_pkg::q_t px,
                                                input bld_pkg::q_t py);
    bld_pkg::res_t r;
    bld_pkg::q_t   ux, uy, dx, dy;
    longint        ex, ey;
    int            n;
    r.conv = 1'b1;
    n = 0;
    ux = px;
    uy = py;
    lens_offset(ux, uy, dx, dy);
    if (!remove) begin
      ux = add_q(px, dx);
      uy = add_q(py, dy);
    end else begin
      forever begin
        ex = longint'(ux) + dx - px;
        ey = longint'(uy) + dy - py;
        if (ex < 0) ex = -ex;
        if (ey < 0) ey = -ey;
        if (ex + ey <= longint'(tol_m)) break;
        if (n >= bld_pkg::MaxIter) begin
          r.conv = 1'b0;
          break;
        end
        ux = sat_q(longint'(px) - dx);
        uy = sat_q(longint'(py) - dy);
        lens_offset(ux, uy, dx, dy);
        n++;
      end
    end
    r.x = ux;
    r.y = uy;
    r.iters = bld_pkg::IterW'(n);
    return r;
  endfunction

  function automatic bld_pkg::q_t rand_span(input int unsigned span);
    return bld_pkg::q_t'(longint'($urandom_range(0, 2 * span)) - longint'(span));
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bld_pkg::CfgK1:  k1_m = d;
      bld_pkg::CfgK2:  k2_m = d;
      bld_pkg::CfgK3:  k3_m = d;
      bld_pkg::CfgT1:  t1_m = d;
      bld_pkg::CfgT2:  t2_m = d;
      bld_pkg::CfgTol: tol_m = d[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    repeat ($urandom_range(0, 3)) @(posedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic load_coeffs(input bld_pkg::q_t k1, input bld_pkg::q_t k2,
                             input bld_pkg::q_t k3, input bld_pkg::q_t t1,
                             input bld_pkg::q_t t2, input logic [15:0] tol);
    wait_drained();
    reg_write(bld_pkg::CfgK1, k1);
    reg_write(bld_pkg::CfgK2, k2);
    reg_write(bld_pkg::CfgK3, k3);
    reg_write(bld_pkg::CfgT1, t1);
    reg_write(bld_pkg::CfgT2, t2);
    reg_write(bld_pkg::CfgTol, {16'($urandom_range(0, 65535)), tol});
    reg_write($urandom_range(0, 1) ? CfgSpare6 : CfgSpare7, $urandom);
  endtask

  task automatic send_point(input row_t row);
    int g;
    g = 0;
    if ($urandom_range(0, 99) < 30) g = ($urandom_range(0, 19) == 0) ?
                                       $urandom_range(10, 120) : $urandom_range(1, 3);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push        <= 1'b1;
    in_req_type <= row.remove;
    in_point_x  <= row.x;
    in_point_y  <= row.y;
    do @(posedge clk); while (full);
    pending_q.push_back(row.typed ? row.ans : lens_result(row.remove, row.x, row.y));
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold = pop_hold - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 99) < 20)
        pop_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 4);
    end
  end

  always @(posedge clk) begin
    bld_pkg::res_t e;
    if (rst_n && pop && !empty) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h", $time, out_out_x, out_out_y);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_out_x !== e.x) begin
          $display("%0t: out_x expected %h actual %h", $time, e.x, out_out_x);
          errors++;
        end
        if (out_out_y !== e.y) begin
          $display("%0t: out_y expected %h actual %h", $time, e.y, out_out_y);
          errors++;
        end
        if (out_converged !== e.conv) begin
          $display("%0t: converged expected %b actual %b", $time, e.conv, out_converged);
          errors++;
        end
        if (out_iteration_count !== e.iters) begin
          $display("%0t: iteration_count expected %0d actual %0d", $time, e.iters,
                   out_iteration_count);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t        r;
    bld_pkg::q_t span;
    k1_m = '0; k2_m = '0; k3_m = '0; t1_m = '0; t2_m = '0; tol_m = 16'd1;
    // zero coefficients: add and remove both return the point itself
    dir_tab[0]  = '{1'b0, QMax, QMax, 1'b1, '{QMax, QMax, 1'b1, 9'd0}};
    dir_tab[1]  = '{1'b0, QMin, QMin, 1'b1, '{QMin, QMin, 1'b1, 9'd0}};
    dir_tab[2]  = '{1'b1, QMax, QMin, 1'b1, '{QMax, QMin, 1'b1, 9'd0}};
    dir_tab[3]  = '{1'b1, QMin, QMax, 1'b1, '{QMin, QMax, 1'b1, 9'd0}};
    dir_tab[4]  = '{1'b0, '0, '0, 1'b1, '{'0, '0, 1'b1, 9'd0}};
    dir_tab[5]  = '{1'b1, '0, '0, 1'b1, '{'0, '0, 1'b1, 9'd0}};
    dir_tab[6]  = '{1'b0, QOne, -QOne, 1'b1, '{QOne, -QOne, 1'b1, 9'd0}};
    dir_tab[7]  = '{1'b1, 32'sh05555555, 32'shfaaaaaab, 1'b1,
                    '{32'sh05555555, 32'shfaaaaaab, 1'b1, 9'd0}};
    dir_tab[8]  = '{1'b0, QOne >>> 1, QOne >>> 2, 1'b0, '{default: '0}};
    dir_tab[9]  = '{1'b1, QOne >>> 1, QOne >>> 2, 1'b0, '{default: '0}};
    dir_tab[10] = '{1'b1, QOne, QOne, 1'b0, '{default: '0}};
    dir_tab[11] = '{1'b0, QMax, QMin, 1'b0, '{default: '0}};
    dir_tab[12] = '{1'b1, QMin, QMax, 1'b0, '{default: '0}};
    dir_tab[13] = '{1'b1, -(QOne >>> 3), QOne >>> 4, 1'b0, '{default: '0}};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 8; i++) send_point(dir_tab[i]);
    for (int c = 0; c < 3; c++) begin
      case (c)
        0: load_coeffs(32'sh01000000, 32'shff800000, 32'sh00200000, 32'sh00100000,
                       32'shfff00000, 16'd4);
        1: load_coeffs(32'shfc000000, 32'sh00400000, '0, '0, 32'sh00080000, 16'd0);
        default: load_coeffs(QMax, QMax, QMax, QMin, QMax, 16'd65535);
      endcase
      for (int i = 8; i < 14; i++) send_point(dir_tab[i]);
    end

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: load_coeffs(QMin, QMin, QMin, QMax, QMin, 16'd0);
        1: load_coeffs(QMax, QMin, QMax, QMin, QMax, 16'hffff);
        default: load_coeffs(rand_span(32'h04000000), rand_span(32'h01000000),
                             rand_span(32'h00400000), rand_span(32'h00400000),
                             rand_span(32'h00400000),
                             ($urandom_range(0, 3) == 0) ? 16'd0 :
                                                           16'($urandom_range(0, 64)));
      endcase
      for (int i = 0; i < 165; i++) begin
        r.typed  = 1'b0;
        r.ans    = '{default: '0};
        r.remove = ($urandom_range(0, 99) < 70);
        if ($urandom_range(0, 9) == 0 || ph < 2) begin
          r.x = $urandom;
          r.y = $urandom;
        end else begin
          span = ($urandom_range(0, 3) == 0) ? QOne : (QOne >>> 2);
          r.x = rand_span(span);
          r.y = rand_span(span);
        end
        send_point(r);
      end
    end
    push <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/bld_pkg.sv
design/bld_front.sv
design/bld_engine.sv
design/brown_lens_distortion_top.sv
design/bld_checker.sv
sim/tb_brown_lens_distortion_top.sv
